// ===== rtl/htcf_pkg.sv =====
`timescale 1ns / 1ps

package htcf_pkg;

  // default fractional widths of the result and of the interpolation weights
  localparam int unsigned FactorFracBitsDef = 14;
  localparam int unsigned WeightFracBitsDef = 12;

  // field widths
  localparam int unsigned HumW    = 10;
  localparam int unsigned TempW   = 11;
  localparam int unsigned FactorW = 16;
  localparam int unsigned RegionW = 2;
  localparam int unsigned ValW    = 8;
  localparam int unsigned OffxW   = 8;
  localparam int unsigned OffyW   = 7;

  // queue between classifier and datapath
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = 2;

  // spans of the interpolation cells
  localparam int unsigned HumSpanLo = 250;
  localparam int unsigned HumSpanHi = 200;
  localparam int unsigned TempStep  = 100;

  // humidity breakpoints, tenths of a percent
  localparam logic [HumW-1:0] HumLo  = 10'd400;
  localparam logic [HumW-1:0] HumMid = 10'd650;
  localparam logic [HumW-1:0] HumHi  = 10'd850;

  // temperature breakpoints, tenths of a degree
  localparam logic signed [TempW-1:0] TempCold = -11'sd100;
  localparam logic signed [TempW-1:0] TempZero = 11'sd0;
  localparam logic signed [TempW-1:0] TempLo   = 11'sd100;
  localparam logic signed [TempW-1:0] Temp200  = 11'sd200;
  localparam logic signed [TempW-1:0] Temp300  = 11'sd300;
  localparam logic signed [TempW-1:0] Temp400  = 11'sd400;
  localparam logic signed [TempW-1:0] TempHi   = 11'sd500;

  // fixed factors in hundredths
  localparam logic [ValW-1:0] ValFreeze = 8'd235;
  localparam logic [ValW-1:0] ValCool   = 8'd160;
  localparam logic [ValW-1:0] ValOne    = 8'd100;

  // table columns used outside the humidity range
  localparam logic [1:0] ColLow  = 2'd0;
  localparam logic [1:0] ColHigh = 2'd2;

  typedef enum logic [RegionW-1:0] {
    RegInterp  = 2'd0,
    RegAbove   = 2'd1,
    RegBelow   = 2'd2,
    RegDefault = 2'd3
  } region_e;

  // classified item handed from the front to the datapath
  typedef struct packed {
    logic             interp;
    region_e          region;
    logic [1:0]       row;
    logic             col;
    logic [OffxW-1:0] offx;
    logic [OffyW-1:0] offy;
    logic [ValW-1:0]  val;
  } item_t;

  // compensation table in hundredths, rows 10..50 C, columns 40/65/85 %
  function automatic logic [ValW-1:0] comp_value(input logic [2:0] row,
                                                  input logic [1:0] col);
    logic [ValW-1:0] v;
    case ({row, col})
      5'b000_00: v = 8'd161;
      5'b000_01: v = 8'd142;
      5'b000_10: v = 8'd125;
      5'b001_00: v = 8'd130;
      5'b001_01: v = 8'd100;
      5'b001_10: v = 8'd93;
      5'b010_00: v = 8'd99;
      5'b010_01: v = 8'd80;
      5'b010_10: v = 8'd70;
      5'b011_00: v = 8'd78;
      5'b011_01: v = 8'd61;
      5'b011_10: v = 8'd54;
      5'b100_00: v = 8'd64;
      5'b100_01: v = 8'd45;
      5'b100_10: v = 8'd43;
      default:   v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/humidity_temp_compensation_factor.sv =====
`timescale 1ns / 1ps

// Gas-sensor compensation factor from humidity (tenths of a percent) and
// temperature (tenths of a degree C, two's complement).
// Input channel: in_valid_i / in_stall_o with humidity_i and temperature_i;
// an item is taken at a clock edge with in_valid_i high and in_stall_o low.
// Output channel: out_valid_o / out_stall_i with factor_o (unsigned Q2.14 by
// default) and region_o (interpolated, above, below, default unity).
// Throughput: one item per cycle while out_stall_i is low, with no
// dependence between items. A taken item passes from the classifier through
// the four-entry queue and the six-stage datapath (weight lookup, two blend
// multiplies, rescale, reciprocal multiply by 1/25, remainder correction
// into the output register).
// When out_stall_i is held the result stays on the output, the datapath
// fills, then the queue fills, and in_stall_o rises once the queue is full.
// Reset empties the queue and clears all stage valid bits; no table needs
// loading, so items are taken from the first cycle after reset.
module humidity_temp_compensation_factor #(
  parameter int unsigned FACTOR_FRAC_BITS = htcf_pkg::FactorFracBitsDef,
  parameter int unsigned WEIGHT_FRAC_BITS = htcf_pkg::WeightFracBitsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [htcf_pkg::HumW-1:0]         humidity_i,
  input  logic signed [htcf_pkg::TempW-1:0] temperature_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [htcf_pkg::FactorW-1:0]      factor_o,
  output logic [htcf_pkg::RegionW-1:0]      region_o
);
  import htcf_pkg::*;

  item_t front_item;
  item_t queue_item;
  logic  queue_full;
  logic  queue_valid;
  logic  queue_pop;
  logic  push;

  // classify the incoming item
  htcf_front u_front (
    .humidity_i    (humidity_i),
    .temperature_i (temperature_i),
    .item_o        (front_item)
  );

  assign push       = in_valid_i && !queue_full;
  assign in_stall_o = queue_full;

  // decouple classifier from datapath
  htcf_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (front_item),
    .full_o      (queue_full),
    .pop_valid_o (queue_valid),
    .pop_item_o  (queue_item),
    .pop_i       (queue_pop)
  );

  // interpolation and scaling datapath
  htcf_back #(
    .FACTOR_FRAC_BITS (FACTOR_FRAC_BITS),
    .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (queue_valid),
    .item_i      (queue_item),
    .pop_o       (queue_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .factor_o    (factor_o),
    .region_o    (region_o)
  );

endmodule

// ===== rtl/htcf_front.sv =====
`timescale 1ns / 1ps

module htcf_front (
  input  logic [htcf_pkg::HumW-1:0]         humidity_i,
  input  logic signed [htcf_pkg::TempW-1:0] temperature_i,
  output htcf_pkg::item_t                   item_o
);
  import htcf_pkg::*;

  logic       hum_in;
  logic       temp_in;
  logic       hum_above;
  logic [8:0] temp_off;
  logic [1:0] irow;
  logic [2:0] frow;

  // range checks and band selection
  always_comb begin
    hum_in    = (humidity_i >= HumLo) && (humidity_i <= HumHi);
    temp_in   = (temperature_i >= TempLo) && (temperature_i <= TempHi);
    hum_above = humidity_i > HumHi;
    temp_off  = 9'(temperature_i - TempLo);

    // interpolation row, top band keeps the upper breakpoint
    if (temperature_i >= Temp400)      irow = 2'd3;
    else if (temperature_i >= Temp300) irow = 2'd2;
    else if (temperature_i >= Temp200) irow = 2'd1;
    else                               irow = 2'd0;

    // table row at or below the temperature, outside the humidity range
    if (temperature_i >= TempHi)       frow = 3'd4;
    else if (temperature_i >= Temp400) frow = 3'd3;
    else if (temperature_i >= Temp300) frow = 3'd2;
    else if (temperature_i >= Temp200) frow = 3'd1;
    else                               frow = 3'd0;
  end

  // build the classified item
  always_comb begin
    item_o        = '0;
    item_o.interp = 1'b0;
    item_o.region = RegDefault;
    item_o.val    = ValOne;
    item_o.row    = irow;
    item_o.col    = humidity_i >= HumMid;
    item_o.offx   = item_o.col ? OffxW'(humidity_i - HumMid) : OffxW'(humidity_i - HumLo);
    item_o.offy   = OffyW'(temp_off - 9'(TempStep * irow));
    if (hum_in) begin
      if (temp_in) begin
        item_o.interp = 1'b1;
        item_o.region = RegInterp;
      end
    end else if (temperature_i >= TempCold) begin
      item_o.region = hum_above ? RegAbove : RegBelow;
      if (temperature_i <= TempZero) begin
        item_o.val = ValFreeze;
      end else if (temperature_i < TempLo) begin
        item_o.val = ValCool;
      end else begin
        item_o.val = comp_value(frow, hum_above ? ColHigh : ColLow);
      end
    end
  end

endmodule

// ===== rtl/htcf_queue.sv =====
`timescale 1ns / 1ps

module htcf_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  htcf_pkg::item_t push_item_i,
  output logic            full_o,
  output logic            pop_valid_o,
  output htcf_pkg::item_t pop_item_o,
  input  logic            pop_i
);
  import htcf_pkg::*;

  localparam int unsigned CntW = QueuePtrW + 1;

  item_t                entry_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q;
  logic [QueuePtrW-1:0] rd_ptr_q;
  logic [CntW-1:0]      count_q;

  assign full_o      = count_q == CntW'(QueueDepth);
  assign pop_valid_o = count_q != '0;
  assign pop_item_o  = entry_q[rd_ptr_q];

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      count_q <= count_q + CntW'(push_i) - CntW'(pop_i);
    end
  end

  // item storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_item_i;
    end
  end

  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |-> count_q == $past(count_q) + CntW'($past(push_i)) - CntW'($past(pop_i)))
    else $error("queue fill level out of step with push and pop");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(QueueDepth))
    else $error("queue fill level beyond depth");

  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == '0 |-> wr_ptr_q == rd_ptr_q)
    else $error("empty queue with pointers apart");

endmodule

// ===== rtl/htcf_back.sv =====
`timescale 1ns / 1ps

module htcf_back #(
  parameter int unsigned FACTOR_FRAC_BITS = htcf_pkg::FactorFracBitsDef,
  parameter int unsigned WEIGHT_FRAC_BITS = htcf_pkg::WeightFracBitsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  htcf_pkg::item_t                item_i,
  output logic                           pop_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [htcf_pkg::FactorW-1:0]   factor_o,
  output logic [htcf_pkg::RegionW-1:0]   region_o
);
  import htcf_pkg::*;

  localparam int unsigned W          = WEIGHT_FRAC_BITS;
  localparam int unsigned F          = FACTOR_FRAC_BITS;
  localparam int unsigned XW         = W + 10;
  localparam int unsigned SFW        = 2 * W + 11;
  localparam int unsigned SW         = 2 * W + 8;
  localparam int unsigned PW         = F + 8;
  localparam int unsigned QW         = F + 6;
  localparam int unsigned MW         = QW - 4;
  localparam int unsigned PRW        = QW + MW;
  localparam int unsigned NumStages  = 6;
  localparam int unsigned DivAfterShift = 25;
  localparam int unsigned HalfHundred   = 50;
  localparam int unsigned RecipDiv   = (1 << QW) / DivAfterShift;
  localparam int unsigned OffxDepth  = 1 << OffxW;
  localparam int unsigned OffyDepth  = 1 << OffyW;
  localparam logic [FactorW-1:0] FactorMax   = '1;
  localparam logic [FactorW-1:0] UnityFactor = (F >= FactorW) ? FactorMax : FactorW'(1 << F);

  // weight tables: round-half-up offset / span in Q1.W
  logic [W:0] wx_lo_tab [OffxDepth];
  logic [W:0] wx_hi_tab [OffxDepth];
  logic [W:0] wy_tab    [OffyDepth];

  for (genvar i = 0; i < OffxDepth; i++) begin : g_wx
    localparam int unsigned WxLo = ((i << W) + HumSpanLo / 2) / HumSpanLo;
    localparam int unsigned WxHi = ((i << W) + HumSpanHi / 2) / HumSpanHi;
    assign wx_lo_tab[i] = WxLo[W:0];
    assign wx_hi_tab[i] = WxHi[W:0];
  end

  for (genvar i = 0; i < OffyDepth; i++) begin : g_wy
    localparam int unsigned Wy = ((i << W) + TempStep / 2) / TempStep;
    assign wy_tab[i] = Wy[W:0];
  end

  // stage valid bits and backpressure
  logic [NumStages:1] vld_q;
  logic [NumStages:1] rdy;

  always_comb begin
    rdy[NumStages] = !vld_q[NumStages] || !out_stall_i;
    for (int k = NumStages - 1; k >= 1; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  assign pop_o = in_valid_i && rdy[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[1]) vld_q[1] <= in_valid_i;
      for (int k = 2; k <= NumStages; k++) begin
        if (rdy[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  // stage 1: weights and cell corners
  logic [W:0]      s1_wx_q, s1_wy_q;
  logic [ValW-1:0] s1_ca_q, s1_cb_q, s1_cc_q, s1_cd_q, s1_val_q;
  logic            s1_interp_q;
  region_e         s1_region_q;
  logic [2:0]      row_lo, row_hi;
  logic [1:0]      col_lo, col_hi;

  always_comb begin
    row_lo = {1'b0, item_i.row};
    row_hi = row_lo + 3'd1;
    col_lo = {1'b0, item_i.col};
    col_hi = col_lo + 2'd1;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      s1_wx_q     <= item_i.col ? wx_hi_tab[item_i.offx] : wx_lo_tab[item_i.offx];
      s1_wy_q     <= wy_tab[item_i.offy];
      s1_ca_q     <= comp_value(row_lo, col_lo);
      s1_cb_q     <= comp_value(row_lo, col_hi);
      s1_cc_q     <= comp_value(row_hi, col_lo);
      s1_cd_q     <= comp_value(row_hi, col_hi);
      s1_val_q    <= item_i.val;
      s1_interp_q <= item_i.interp;
      s1_region_q <= item_i.region;
    end
  end

  // stage 2: blend along humidity for both rows
  logic signed [XW-1:0] s2_x1_q, s2_x2_q;
  logic [W:0]           s2_wy_q;
  logic [ValW-1:0]      s2_val_q;
  logic                 s2_interp_q;
  region_e              s2_region_q;
  logic signed [8:0]    d_ab, d_cd;
  logic signed [W+1:0]  wx_s;
  logic signed [XW-1:0] x1_d, x2_d;

  always_comb begin
    d_ab = $signed({1'b0, s1_cb_q}) - $signed({1'b0, s1_ca_q});
    d_cd = $signed({1'b0, s1_cd_q}) - $signed({1'b0, s1_cc_q});
    wx_s = $signed({1'b0, s1_wx_q});
    x1_d = (XW'($signed({1'b0, s1_ca_q})) <<< W) + XW'(d_ab) * XW'(wx_s);
    x2_d = (XW'($signed({1'b0, s1_cc_q})) <<< W) + XW'(d_cd) * XW'(wx_s);
  end

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      s2_x1_q     <= x1_d;
      s2_x2_q     <= x2_d;
      s2_wy_q     <= s1_wy_q;
      s2_val_q    <= s1_val_q;
      s2_interp_q <= s1_interp_q;
      s2_region_q <= s1_region_q;
    end
  end

  // stage 3: blend along temperature, fixed values aligned to the same scale
  logic [SW-1:0]         s3_sum_q;
  region_e               s3_region_q;
  logic signed [XW-1:0]  dx;
  logic signed [W+1:0]   wy_s;
  logic signed [SFW-1:0] sum_full;

  always_comb begin
    dx       = s2_x2_q - s2_x1_q;
    wy_s     = $signed({1'b0, s2_wy_q});
    sum_full = (SFW'(s2_x1_q) <<< W) + SFW'(dx) * SFW'(wy_s);
  end

  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      s3_sum_q    <= s2_interp_q ? sum_full[SW-1:0] : {s2_val_q, {(2 * W){1'b0}}};
      s3_region_q <= s2_region_q;
    end
  end

  // stage 4: rescale to Q.F, add half of the hundred, drop two bits of the divisor
  logic [QW-1:0]   s4_q_q;
  region_e         s4_region_q;
  logic [SW+F-1:0] widened;
  logic [PW-1:0]   scaled;

  always_comb begin
    widened = {s3_sum_q, {F{1'b0}}};
    scaled  = widened[SW+F-1 -: PW] + PW'(HalfHundred);
  end

  always_ff @(posedge clk_i) begin
    if (rdy[4]) begin
      s4_q_q      <= scaled[PW-1:2];
      s4_region_q <= s3_region_q;
    end
  end

  // stage 5: reciprocal multiply, quotient estimate low by at most one
  logic [MW-1:0]  s5_q0_q;
  logic [QW-1:0]  s5_num_q;
  region_e        s5_region_q;
  logic [PRW-1:0] recip_prod;

  assign recip_prod = PRW'(s4_q_q) * PRW'(RecipDiv);

  always_ff @(posedge clk_i) begin
    if (rdy[5]) begin
      s5_q0_q     <= recip_prod[PRW-1 -: MW];
      s5_num_q    <= s4_q_q;
      s5_region_q <= s4_region_q;
    end
  end

  // stage 6: remainder correction and saturation into the output register
  logic [FactorW-1:0] s6_factor_q;
  region_e            s6_region_q;
  logic [QW-1:0]      q0_x25;
  logic [QW-1:0]      rem;
  logic [MW:0]        quot;
  logic [FactorW-1:0] factor_d;

  always_comb begin
    q0_x25   = (QW'(s5_q0_q) << 4) + (QW'(s5_q0_q) << 3) + QW'(s5_q0_q);
    rem      = s5_num_q - q0_x25;
    quot     = (MW+1)'(s5_q0_q) + (MW+1)'(rem >= QW'(DivAfterShift));
    factor_d = (32'(quot) > 32'(FactorMax)) ? FactorMax : FactorW'(quot);
  end

  always_ff @(posedge clk_i) begin
    if (rdy[6]) begin
      s6_factor_q <= factor_d;
      s6_region_q <= s5_region_q;
    end
  end

  assign out_valid_o = vld_q[NumStages];
  assign factor_o    = s6_factor_q;
  assign region_o    = s6_region_q;

  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[5] |-> rem < QW'(2 * DivAfterShift))
    else $error("reciprocal estimate off by more than one");

  a_default_unity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[NumStages] && s6_region_q == RegDefault |-> s6_factor_q == UnityFactor)
    else $error("default region without unity factor");

endmodule

// ===== bench/tb_humidity_temp_compensation_factor.sv =====
`timescale 1ns / 1ps

module tb_humidity_temp_compensation_factor;
  import htcf_pkg::*;

  localparam int unsigned FactorFrac = FactorFracBitsDef;
  localparam int unsigned WeightFrac = WeightFracBitsDef;
  localparam int unsigned StallLimit = 1000;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned RandomItems = 400;
  localparam int unsigned MaxPrinted = 50;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic [HumW-1:0]          humidity_i;
  logic signed [TempW-1:0]  temperature_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic [FactorW-1:0]       factor_o;
  logic [RegionW-1:0]       region_o;

  humidity_temp_compensation_factor #(
    .FACTOR_FRAC_BITS(FactorFrac),
    .WEIGHT_FRAC_BITS(WeightFrac)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .humidity_i   (humidity_i),
    .temperature_i(temperature_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .factor_o     (factor_o),
    .region_o     (region_o)
  );

  // one reading with the factor and region it should produce
  typedef struct {
    logic [HumW-1:0]         hum;
    logic signed [TempW-1:0] temp;
    logic [FactorW-1:0]      factor;
    region_e                 region;
  } factor_expect_t;

  class factor_scoreboard;
    factor_expect_t expected_factors[$];
    int unsigned    comp_hund[5][3];
    int unsigned    mismatches;

    function new();
      comp_hund = '{'{161, 142, 125},
                    '{130, 100, 93},
                    '{99, 80, 70},
                    '{78, 61, 54},
                    '{64, 45, 43}};
      mismatches = 0;
    endfunction

    // hundredths to Q2.frac, rounded half up, saturated
    function longint unsigned hund_to_q(longint unsigned v);
      longint unsigned q;
      q = ((v << FactorFrac) + 50) / 100;
      return (q > 65535) ? 65535 : q;
    endfunction

    // round-half-up weight of off within span
    function longint unsigned cell_weight(longint unsigned off, longint unsigned span);
      return ((off << WeightFrac) + span / 2) / span;
    endfunction

    // bilinear blend inside the table
    function longint unsigned blend_cell(int unsigned h, int t);
      longint unsigned unit_w, wx, wy, x1, x2, acc, den, q;
      int unsigned col, hbase, hspan, row, toff;
      unit_w = longint'(1) << WeightFrac;
      col = (h < int'(HumMid)) ? 0 : 1;
      hbase = col ? int'(HumMid) : int'(HumLo);
      hspan = col ? (int'(HumHi) - int'(HumMid)) : (int'(HumMid) - int'(HumLo));
      toff = t - int'(TempLo);
      row = toff / 100;
      if (row > 3) row = 3;
      wx = cell_weight(64'(h - hbase), 64'(hspan));
      wy = cell_weight(64'(toff - row * 100), 64'(100));
      x1 = comp_hund[row][col] * (unit_w - wx) + comp_hund[row][col + 1] * wx;
      x2 = comp_hund[row + 1][col] * (unit_w - wx) + comp_hund[row + 1][col + 1] * wx;
      acc = x1 * (unit_w - wy) + x2 * wy;
      den = longint'(100) << (2 * WeightFrac);
      q = ((acc << FactorFrac) + den / 2) / den;
      return (q > 65535) ? 65535 : q;
    endfunction

    function void predict_factor(logic [HumW-1:0] hum, logic signed [TempW-1:0] temp,
                                 output logic [FactorW-1:0] fac, output region_e reg_o);
      int          t;
      int unsigned h, row, col;
      t = int'(temp);
      h = 32'(hum);
      fac = FactorW'(hund_to_q(64'(ValOne)));
      reg_o = RegDefault;
      if (h >= HumLo && h <= HumHi) begin
        if (t >= int'(TempLo) && t <= int'(TempHi)) begin
          fac = FactorW'(blend_cell(h, t));
          reg_o = RegInterp;
        end
      end else if (t >= int'(TempCold)) begin
        col = (h > HumHi) ? 32'(ColHigh) : 32'(ColLow);
        reg_o = (h > HumHi) ? RegAbove : RegBelow;
        if (t <= int'(TempZero)) begin
          fac = FactorW'(hund_to_q(64'(ValFreeze)));
        end else if (t < int'(TempLo)) begin
          fac = FactorW'(hund_to_q(64'(ValCool)));
        end else begin
          row = (t - int'(TempLo)) / 100;
          if (row > 4) row = 4;
          fac = FactorW'(hund_to_q(64'(comp_hund[row][col])));
        end
      end
    endfunction

    function void note_reading(logic [HumW-1:0] hum, logic signed [TempW-1:0] temp);
      factor_expect_t e;
      e.hum = hum;
      e.temp = temp;
      predict_factor(hum, temp, e.factor, e.region);
      expected_factors.push_back(e);
    endfunction

    task report(string msg);
      if (mismatches < MaxPrinted) $display("mismatch: %s", msg);
      mismatches++;
    endtask

    task check_result(logic [FactorW-1:0] fac, logic [RegionW-1:0] reg_v);
      factor_expect_t e;
      if (expected_factors.size() == 0) begin
        report($sformatf("result factor=%0d region=%0d with no reading pending",
                         fac, reg_v));
      end else begin
        e = expected_factors.pop_front();
        if (fac !== e.factor)
          report($sformatf("h=%0d t=%0d factor got %0d want %0d",
                           e.hum, e.temp, fac, e.factor));
        if (reg_v !== e.region)
          report($sformatf("h=%0d t=%0d region got %0d want %0d",
                           e.hum, e.temp, reg_v, e.region));
      end
    endtask

    function int unsigned pending();
      return expected_factors.size();
    endfunction
  endclass

  factor_scoreboard sb;
  int unsigned      sent_count;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // gap length, zero during burst stretches
  function automatic int unsigned idle_draw(bit burst);
    return burst ? 0 : $urandom_range(0, 15);
  endfunction

  // offer one reading; entered and left just after a falling edge
  task automatic send_reading(logic [HumW-1:0] hum, logic signed [TempW-1:0] temp);
    int unsigned gap;
    gap = idle_draw(((sent_count / 40) % 3) == 2);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    humidity_i    <= hum;
    temperature_i <= temp;
    forever begin
      @(posedge clk_i);
      if (in_stall_o === 1'b0) break;
    end
    sb.note_reading(hum, temp);
    sent_count++;
    @(negedge clk_i);
  endtask

  // random reading, mostly inside the interpolation cell
  task automatic send_random_reading();
    int unsigned             pick;
    logic [HumW-1:0]         hum;
    logic signed [TempW-1:0] temp;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      hum  = HumW'($urandom_range(HumLo, HumHi));
      temp = TempW'($urandom_range(TempLo, TempHi));
    end else if (pick < 55) begin
      // exact breakpoints
      case ($urandom_range(0, 3))
        0: hum = HumLo;
        1: hum = HumW'(HumMid - 1);
        2: hum = HumMid;
        default: hum = HumHi;
      endcase
      temp = TempW'(100 * $urandom_range(1, 5) - $urandom_range(0, 1));
    end else if (pick < 80) begin
      hum  = $urandom_range(0, 1) ? HumW'($urandom_range(0, HumLo - 1))
                                  : HumW'($urandom_range(HumHi + 1, 1023));
      temp = TempW'(int'($urandom_range(0, 750)) - 150);
    end else begin
      hum  = HumW'($urandom());
      temp = TempW'($urandom());
    end
    send_reading(hum, temp);
  endtask

  // stimulus and end of run
  initial begin
    sb            = new();
    sent_count    = 0;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    humidity_i    = '0;
    temperature_i = '0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // corners, breakpoints and each region
    send_reading(10'd400, 11'sd100);
    send_reading(10'd850, 11'sd500);
    send_reading(10'd649, 11'sd199);
    send_reading(10'd650, 11'sd200);
    send_reading(10'd400, 11'sd500);
    send_reading(10'd850, 11'sd100);
    send_reading(10'd525, 11'sd350);
    send_reading(10'd750, 11'sd400);
    send_reading(10'd600, 11'sd300);
    send_reading(10'd399, -11'sd100);
    send_reading(10'd399, -11'sd101);
    send_reading(10'd851, 11'sd0);
    send_reading(10'd851, 11'sd1);
    send_reading(10'd0, 11'sd99);
    send_reading(10'd1023, 11'sd100);
    send_reading(10'd1023, 11'sd200);
    send_reading(10'd0, 11'sd499);
    send_reading(10'd0, 11'sd500);
    send_reading(10'd1023, 11'sd1023);
    send_reading(10'd0, -11'sd1024);
    send_reading(10'd400, 11'sd99);
    send_reading(10'd850, 11'sd501);
    send_reading(10'd700, -11'sd50);
    send_reading(10'd1023, -11'sd100);
    send_reading(10'd399, 11'sd450);

    repeat (RandomItems) send_random_reading();
    in_valid_i <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("PASS humidity_temp_compensation_factor");
    end else begin
      $display("FAIL humidity_temp_compensation_factor");
    end
    $finish;
  end

  // receiver: random stalls, burst stretches and one long hold-off
  initial begin : receiver
    int unsigned taken;
    int unsigned hold;
    taken = 0;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      hold = (taken == 120) ? 150 : idle_draw(((taken / 50) % 3) == 1);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      forever begin
        @(posedge clk_i);
        if (out_valid_o === 1'b1) break;
      end
      taken++;
      @(negedge clk_i);
    end
  end

  // result check
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0)
      sb.check_result(factor_o, region_o);
  end

  // watchdog on cycles with no item moving
  int unsigned quiet_cycles = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= StallLimit) begin
        $display("FAIL humidity_temp_compensation_factor");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

endmodule
